@@ rtl/assert_macros.svh @@
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ART_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define ART_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/art_pkg.sv @@
// shared types and constants of the aging route table
`timescale 1ns / 1ps
package art_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int KEY_W   = 48;
    localparam int HOP_W   = 48;
    localparam int IFACE_W = 16;
    localparam int COST_W  = 8;
    localparam int SEQ_W   = 16;
    localparam int TIME_W  = 32;
    localparam int LIFE_W  = 31;

    localparam int S_TDATA_W = 168;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 3;

    localparam logic [LIFE_W-1:0] LIFETIME_RST = 31'd120000;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam int U_FOUND   = 0;
    localparam int U_EXPIRED = 1;
    localparam int U_FULL    = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic last_addr;
        logic out_busy;
    } t_status;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [COST_W-1:0]  cost;
        logic [IFACE_W-1:0] iface;
        logic [HOP_W-1:0]   hop;
    } t_payload;

    typedef struct packed {
        logic [TIME_W-1:0]  now_time;
        logic [SEQ_W-1:0]   seq_number;
        logic [COST_W-1:0]  cost;
        logic [IFACE_W-1:0] iface;
        logic [HOP_W-1:0]   next_hop;
        logic [KEY_W-1:0]   destination;
    } t_s_data;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [KEY_W-1:0]  key;
        t_payload          data;
    } t_entry;

endpackage

@@ rtl/art_ctrl.sv @@
// request sequencer: accept, scan, drain and commit
`timescale 1ns / 1ps
module art_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  art_pkg::t_status i_status,
    output art_pkg::t_cmd    o_cmd
);
    import art_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.last_addr) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!i_status.out_busy) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_COMMIT: begin
                o_cmd.commit = !i_status.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/art_dp.sv @@
// entry memory, scan compare, update and result register
`timescale 1ns / 1ps
module art_dp #(
    parameter int ENTRIES = art_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  art_pkg::t_cmd                 i_cmd,
    output art_pkg::t_status              o_status,
    input  logic [art_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [art_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                          i_cfg_valid,
    input  logic [art_pkg::LIFE_W-1:0]    i_cfg_data,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [art_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [art_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import art_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_s_data                r_req;
    logic                   r_req_type;
    logic [LIFE_W-1:0]      r_life;
    logic [ENTRIES-1:0]     r_valid;
    t_entry                 r_mem [ENTRIES];
    logic [AW-1:0]          r_addr;
    logic                   r_rd_vld;
    logic [AW-1:0]          r_rd_idx;
    t_entry                 r_rd_entry;
    logic                   r_rd_slot_vld;
    logic                   r_hit;
    logic                   r_hit_exp;
    logic [AW-1:0]          r_hit_idx;
    t_payload               r_hit_data;
    logic                   r_free;
    logic [AW-1:0]          r_free_idx;
    logic                   r_out_valid;
    t_payload               r_out_data;
    logic [M_TUSER_W-1:0]   r_out_user;

    logic [TIME_W-1:0]      w_diff;
    logic                   w_exp;
    logic                   w_match;
    logic                   w_freeable;
    logic                   w_add;
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_idx;
    logic                   w_full;
    logic                   w_live;
    logic                   w_remove;
    t_entry                 w_new;

    assign w_diff     = r_rd_entry.expiry - r_req.now_time;
    assign w_exp      = w_diff[TIME_W-1];
    assign w_match    = r_rd_slot_vld && (r_rd_entry.key == r_req.destination);
    assign w_freeable = !r_rd_slot_vld || w_exp;

    assign w_add    = (r_req_type == REQ_ADD);
    assign w_wr_en  = i_cmd.commit && w_add && (r_hit || r_free);
    assign w_wr_idx = r_hit ? r_hit_idx : r_free_idx;
    assign w_full   = w_add && !r_hit && !r_free;
    assign w_live   = (r_req_type == REQ_LOOKUP) && r_hit && !r_hit_exp;
    assign w_remove = (r_req_type == REQ_LOOKUP) && r_hit && r_hit_exp;

    assign w_new.expiry     = r_req.now_time + {1'b0, r_life};
    assign w_new.key        = r_req.destination;
    assign w_new.data.hop   = r_req.next_hop;
    assign w_new.data.iface = r_req.iface;
    assign w_new.data.cost  = r_req.cost;
    assign w_new.data.seq   = r_req.seq_number;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= t_s_data'(i_s_tdata);
            r_req_type <= i_s_tuser[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_life <= LIFETIME_RST;
        end else if (i_cfg_valid) begin
            r_life <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_wr_en) begin
            r_valid[w_wr_idx] <= 1'b1;
        end else if (i_cmd.commit && w_remove) begin
            r_valid[r_hit_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_entry    <= r_mem[r_addr];
            r_rd_slot_vld <= r_valid[r_addr];
            r_rd_idx      <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.scan) begin
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    // first matching key and first free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_rd_vld) begin
            if (!r_hit && w_match) begin
                r_hit <= 1'b1;
            end
            if (!r_free && w_freeable) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && !r_hit && w_match) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_exp  <= w_exp;
            r_hit_data <= r_rd_entry.data;
        end
        if (r_rd_vld && !r_free && w_freeable) begin
            r_free_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data           <= w_live ? r_hit_data : '0;
            r_out_user[U_FOUND]   <= w_live;
            r_out_user[U_EXPIRED] <= w_remove;
            r_out_user[U_FULL]    <= w_full;
        end
    end

    assign o_status.last_addr = (r_addr == AW'(ENTRIES - 1));
    assign o_status.out_busy  = r_out_valid && !i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out_data);
    assign o_m_tuser  = r_out_user;

endmodule

@@ rtl/aging_route_table_top.sv @@
// Aging route table: ENTRIES slots keyed by a 48-bit destination, holding next hop,
// interface, cost, sequence number and a 32-bit expiry time. An add request overwrites
// the slot that holds its key, else takes the lowest slot that is invalid or expired,
// else is dropped with table_full. A lookup returns a live entry; a matching entry whose
// expiry lies before now_time (wrap-safe signed difference) is removed and reported via
// expired_removed. Every request gets exactly one result. Each request walks the entry
// memory one slot per cycle through its single read port, and a request occupies the
// block from accept until its result is registered on the output side, which holds
// the result until taken. Reset clears all valid bits at once; no clearing pass is needed.
// The lifetime register is written through the cfg channel, which is always ready, and
// must only be written while no request is pending.
`timescale 1ns / 1ps
module aging_route_table_top #(
    parameter int ENTRIES = art_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // destination, next_hop, iface, cost, seq_number, now_time
    input  logic [art_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic [art_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hop_out, iface_out, cost_out, seq_out
    output logic [art_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // found, expired_removed, table_full
    output logic [art_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [art_pkg::LIFE_W-1:0]    i_cfg_data
);
    import art_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    art_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    art_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

@@ rtl/art_chk.sv @@
// port-level checker for the aging route table, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module art_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          i_s_tready,
    input logic                          i_m_tvalid,
    input logic                          i_m_tready,
    input logic [art_pkg::M_TDATA_W-1:0] i_m_tdata,
    input logic [art_pkg::M_TUSER_W-1:0] i_m_tuser
);
    import art_pkg::*;

    // at most one of found, expired_removed, table_full
    `ART_ASSERT(a_one_flag, i_clk, i_rst_n, i_m_tvalid |-> ($countones(i_m_tuser) <= 1), "more than one result flag")

    // data fields are zero unless the lookup hit
    `ART_ASSERT(a_miss_zero, i_clk, i_rst_n, (i_m_tvalid && !i_m_tuser[U_FOUND]) |-> (i_m_tdata == '0), "nonzero data without hit")

    // one request at a time
    `ART_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_s_tvalid && i_s_tready) |=> !i_s_tready, "ready right after accept")

    // stalled result holds
    `ART_ASSERT(a_out_hold, i_clk, i_rst_n, (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)), "stalled result changed")

    `ART_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_m_tvalid, "result valid after reset")

endmodule

bind aging_route_table_top art_chk u_art_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

@@ bench/aging_route_table_top_tb.sv @@
// self-checking bench for the aging route table: directed rows, then random traffic per lifetime
`timescale 1ns / 1ps
module aging_route_table_top_tb;
    import art_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int KEY_POOL    = 24;
    localparam int KEY_AW      = $clog2(KEY_POOL);
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 235;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic     table_full;
        logic     expired_removed;
        logic     found;
        t_payload data;
    } t_route_result;

    typedef struct {
        logic          req;
        t_s_data       fields;
        logic          typed;
        t_route_result result;
    } t_stim_row;

    localparam t_route_result NO_RESULT = '0;
    localparam t_route_result FULL_DROP =
        '{table_full: 1'b1, expired_removed: 1'b0, found: 1'b0, data: '0};
    localparam t_route_result AGED_OUT =
        '{table_full: 1'b0, expired_removed: 1'b1, found: 1'b0, data: '0};
    localparam t_route_result HIT_ONES =
        '{table_full: 1'b0, expired_removed: 1'b0, found: 1'b1, data: '1};
    localparam t_route_result HIT_ZEROS =
        '{table_full: 1'b0, expired_removed: 1'b0, found: 1'b1, data: '0};

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [LIFE_W-1:0]    i_cfg_data    = '0;

    logic              slot_live [ENTRIES];
    t_entry            slot_store [ENTRIES];
    logic [LIFE_W-1:0] route_lifetime;
    t_route_result     route_expect_q [$];
    t_stim_row         stim_rows [$];
    logic [KEY_W-1:0]  key_pool [KEY_POOL];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatches         = 0;
    int idle_cycles        = 0;
    int results_seen       = 0;
    int hits               = 0;
    int removals           = 0;
    int drops              = 0;

    aging_route_table_top #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[KEY_W-1:0];
    endfunction

    // wrap-safe: expired when expiry lies strictly before now
    function automatic logic aged_out(logic [TIME_W-1:0] expiry, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] diff;
        diff = expiry - now;
        return diff[TIME_W-1];
    endfunction

    function automatic t_route_result route_predict(logic req, t_s_data fields);
        t_route_result res;
        int            hit;
        int            free_slot;
        res = NO_RESULT;
        hit = -1;
        free_slot = -1;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (slot_live[i] && slot_store[i].key == fields.destination)
                hit = i;
            if (!slot_live[i] || aged_out(slot_store[i].expiry, fields.now_time))
                free_slot = i;
        end
        if (req == REQ_ADD) begin
            if (hit < 0)
                hit = free_slot;
            if (hit < 0) begin
                res.table_full = 1'b1;
            end else begin
                slot_live[hit]             = 1'b1;
                slot_store[hit].key        = fields.destination;
                slot_store[hit].data.hop   = fields.next_hop;
                slot_store[hit].data.iface = fields.iface;
                slot_store[hit].data.cost  = fields.cost;
                slot_store[hit].data.seq   = fields.seq_number;
                slot_store[hit].expiry     = fields.now_time + TIME_W'(route_lifetime);
            end
        end else if (hit >= 0) begin
            if (aged_out(slot_store[hit].expiry, fields.now_time)) begin
                slot_live[hit] = 1'b0;
                res.expired_removed = 1'b1;
            end else begin
                res.found = 1'b1;
                res.data  = slot_store[hit].data;
            end
        end
        return res;
    endfunction

    function automatic void stim_row(logic req, logic [KEY_W-1:0] key, logic [HOP_W-1:0] hop,
                                     logic [IFACE_W-1:0] ifc, logic [COST_W-1:0] cst,
                                     logic [SEQ_W-1:0] sq, logic [TIME_W-1:0] now,
                                     logic typed, t_route_result result);
        t_stim_row row;
        row.req                = req;
        row.fields.destination = key;
        row.fields.next_hop    = hop;
        row.fields.iface       = ifc;
        row.fields.cost        = cst;
        row.fields.seq_number  = sq;
        row.fields.now_time    = now;
        row.typed              = typed;
        row.result             = result;
        stim_rows.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                        logic [KEY_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    task automatic send_request(input t_stim_row row);
        t_route_result predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.fields;
        s_axis_tuser  <= row.req;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = route_predict(row.req, row.fields);
        route_expect_q.push_back(row.typed ? row.result : predicted);
    endtask

    task automatic set_lifetime(input logic [LIFE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (route_expect_q.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 3) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        route_lifetime = value;
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        t_route_result got;
        t_route_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.found           = m_axis_tuser[U_FOUND];
            got.expired_removed = m_axis_tuser[U_EXPIRED];
            got.table_full      = m_axis_tuser[U_FULL];
            got.data            = t_payload'(m_axis_tdata);
            results_seen++;
            hits     += int'(got.found);
            removals += int'(got.expired_removed);
            drops    += int'(got.table_full);
            if (route_expect_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with no request pending, expected none, got %0h",
                         $time, got);
            end else begin
                want = route_expect_q.pop_front();
                check_field("found", KEY_W'(want.found), KEY_W'(got.found));
                check_field("expired_removed", KEY_W'(want.expired_removed),
                            KEY_W'(got.expired_removed));
                check_field("table_full", KEY_W'(want.table_full), KEY_W'(got.table_full));
                check_field("hop_out", want.data.hop, got.data.hop);
                check_field("iface_out", KEY_W'(want.data.iface), KEY_W'(got.data.iface));
                check_field("cost_out", KEY_W'(want.data.cost), KEY_W'(got.data.cost));
                check_field("seq_out", KEY_W'(want.data.seq), KEY_W'(got.data.seq));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [TIME_W-1:0] clock_ms;
        logic [LIFE_W-1:0] phase_life [PHASES];
        logic [TIME_W-1:0] phase_step [PHASES];
        t_stim_row         row;
        logic              noise;

        for (int i = 0; i < ENTRIES; i++) begin
            slot_live[i]  = 1'b0;
            slot_store[i] = '0;
        end
        route_lifetime = LIFETIME_RST;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = rand48();

        phase_life = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd50, 31'd120000, 31'd0,
                       31'h7FFF_FFFF, 31'd500};
        phase_life[5] = LIFE_W'($urandom);
        phase_step = '{32'd3, 32'd100, 32'd2, 32'd20, 32'd20000, 32'd0,
                       32'h2000_0000, 32'd100};
        phase_step[5] = TIME_W'(phase_life[5] >> 3) + 32'd1;

        stim_row(REQ_LOOKUP, '0, '0, '0, '0, '0, 32'd0, 1'b1, NO_RESULT);
        stim_row(REQ_LOOKUP, '1, '1, '1, '1, '1, 32'd0, 1'b1, NO_RESULT);
        stim_row(REQ_ADD, '0, '1, '1, '1, '1, 32'd0, 1'b1, NO_RESULT);
        stim_row(REQ_ADD, '1, '0, '0, '0, '0, '1, 1'b1, NO_RESULT);
        stim_row(REQ_LOOKUP, '0, '0, '0, '0, '0, 32'd0, 1'b1, HIT_ONES);
        stim_row(REQ_LOOKUP, '1, '1, '1, '1, '1, 32'd100, 1'b1, HIT_ZEROS);
        stim_row(REQ_LOOKUP, '0, '0, '0, '0, '0, 32'd120001, 1'b1, AGED_OUT);
        for (int k = 1; k < ENTRIES; k++)
            stim_row(REQ_ADD, KEY_W'(k), rand48(), IFACE_W'($urandom), COST_W'($urandom),
                     SEQ_W'($urandom), 32'd1000, 1'b0, NO_RESULT);
        stim_row(REQ_ADD, KEY_W'(ENTRIES), rand48(), '1, '1, '1, 32'd1000, 1'b1, FULL_DROP);
        stim_row(REQ_ADD, KEY_W'(ENTRIES), rand48(), IFACE_W'($urandom), COST_W'($urandom),
                 SEQ_W'($urandom), 32'd200000, 1'b0, NO_RESULT);
        stim_row(REQ_ADD, KEY_W'(2), rand48(), IFACE_W'($urandom), COST_W'($urandom),
                 SEQ_W'($urandom), 32'd200000, 1'b0, NO_RESULT);
        stim_row(REQ_LOOKUP, KEY_W'(2), '0, '0, '0, '0, 32'd320000, 1'b0, NO_RESULT);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i])
            send_request(stim_rows[i]);

        clock_ms = 32'hFFFF_F000;
        for (int p = 0; p < PHASES; p++) begin
            set_lifetime(phase_life[p]);
            sender_idle_pct    = (p % 4 == 1) ? 80 : (p % 4 == 3) ? 34 : 0;
            receiver_stall_pct = (p % 4 == 2) ? 80 : (p % 4 == 3) ? 34 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                noise    = ($urandom_range(99) < 15);
                clock_ms = clock_ms + $urandom_range(phase_step[p]);
                row.req  = 1'($urandom_range(1));
                row.fields.destination = (noise && $urandom_range(1) == 1) ?
                    rand48() : key_pool[KEY_AW'($urandom_range(KEY_POOL - 1))];
                row.fields.next_hop   = rand48();
                row.fields.iface      = IFACE_W'($urandom);
                row.fields.cost       = COST_W'($urandom);
                row.fields.seq_number = SEQ_W'($urandom);
                row.fields.now_time   = (noise && $urandom_range(1) == 1) ?
                                        TIME_W'($urandom) : clock_ms;
                row.typed  = 1'b0;
                row.result = NO_RESULT;
                send_request(row);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (route_expect_q.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 3) @(posedge i_clk);

        $display("ran %0d directed rows and %0d random requests under %0d lifetime settings",
                 stim_rows.size(), PHASES * PHASE_ITEMS, PHASES);
        $display("%0d results checked: %0d hits, %0d aged entries removed, %0d adds dropped",
                 results_seen, hits, removals, drops);
        if (mismatches == 0 && route_expect_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
